>>> design/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int COORD_BITS_DEF = 32;   // default coordinate width
   localparam int FIELD_W        = 32;   // vertex field width on the request
   localparam int NORM_W         = 32;   // normal component width, Q2.30
   localparam int ROOT_W         = 32;   // bits of floor(2^31 * m / |n|)
   localparam int FRAC_SHIFT     = 62;   // 2^62 = (2^31)^2 scale on m^2
   localparam int AXES           = 3;

   localparam logic signed [NORM_W-1:0] UNIT_ONE = 32'sh4000_0000;

endpackage

>>> design/tfn_if.sv
// ----------------------------------------------------------------------------
// tfn_req_if / tfn_rsp_if
// Valid/ready channels carrying one triangle and one unit normal.
// ----------------------------------------------------------------------------
interface tfn_req_if import tfn_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] ax, ay, az;
   logic signed [FIELD_W-1:0] bx, by, bz;
   logic signed [FIELD_W-1:0] cx, cy, cz;

   modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
   modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tfn_rsp_if import tfn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] nx, ny, nz;
   logic                     degenerate;

   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

>>> design/triangle_face_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle in signed Q2.30, exactly rounded.
//
//   channel  dir  payload                       transfer on
//   req_if   in   ax..cz, Q16.16 vertices       valid & ready
//   rsp_if   out  nx, ny, nz Q2.30, degenerate  valid & ready
//
// One triangle per cycle while the skid register is empty; 39 register stages
// from the request transfer to rsp valid: 3 cross product, 2 squaring, 1 sum,
// 32 root recurrence, 1 output.
// The pipeline advances as one while the skid register is empty; the output
// register plus skid register hold two finished results under back-pressure.
// Reset (synchronous) clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module triangle_face_normal_core import tfn_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tfn_req_if.sink    req_if,
   tfn_rsp_if.source  rsp_if
);

   localparam int EDGE_W = COORD_BITS + 1;
   localparam int MAG_W  = 2 * EDGE_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int RW     = SUM_W + FRAC_SHIFT + 2;
   localparam int PW     = SUM_W + ROOT_W;
   localparam int PIPE_N = 6 + ROOT_W;

   logic              en;
   logic [PIPE_N-1:0] v_ff;
   logic [PIPE_N-1:0] v_in;

   logic [MAG_W-1:0]  mag [AXES];
   logic [AXES-1:0]   neg_s2;
   logic [AXES-1:0]   neg_s3_ff, neg_s4_ff;
   logic [SQ_W-1:0]   sq [AXES];

   logic [SUM_W-1:0]  s_st   [ROOT_W+1];
   logic              deg_st [ROOT_W+1];
   logic [AXES-1:0]   neg_st [ROOT_W+1];
   logic [RW-1:0]     r_st   [ROOT_W+1][AXES];
   logic [PW-1:0]     p_st   [ROOT_W+1][AXES];
   logic [ROOT_W-1:0] y_st   [ROOT_W+1][AXES];

   logic [SUM_W-1:0]  s_sum;
   logic [SUM_W-1:0]  s_ff;
   logic              deg_ff;
   logic [AXES-1:0]   neg_ff;
   logic [RW-1:0]     r_ff [AXES];

   logic [ROOT_W:0]          y_inc [AXES];
   logic signed [NORM_W-1:0] fmt [AXES];

   logic                     out_v_ff, skid_v_ff;
   logic signed [NORM_W-1:0] out_n_ff [AXES];
   logic signed [NORM_W-1:0] skid_n_ff [AXES];
   logic                     out_deg_ff, skid_deg_ff;
   logic                     arrive, take;

   // advance the whole pipe unless a result is parked in the skid register
   assign en           = !skid_v_ff;
   assign req_if.ready = en;

   always_comb begin
      v_in[0] = req_if.valid;
      for (int i = 1; i < PIPE_N; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock   (clock),
      .en      (en),
      .ax      (req_if.ax), .ay (req_if.ay), .az (req_if.az),
      .bx      (req_if.bx), .by (req_if.by), .bz (req_if.bz),
      .cx      (req_if.cx), .cy (req_if.cy), .cz (req_if.cz),
      .mag_out (mag),
      .neg_out (neg_s2)
   );

   tfn_square #(.MAG_W(MAG_W)) u_square (
      .clock  (clock),
      .en     (en),
      .mag_in (mag),
      .sq_out (sq)
   );

   assign s_sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_s3_ff <= neg_s2;
         neg_s4_ff <= neg_s3_ff;
         neg_ff    <= neg_s4_ff;
         s_ff      <= s_sum;
         deg_ff    <= (s_sum == '0);
         for (int i = 0; i < AXES; i++) begin
            r_ff[i] <= RW'(sq[i]) << FRAC_SHIFT;
         end
      end
   end

   assign s_st[0]   = s_ff;
   assign deg_st[0] = deg_ff;
   assign neg_st[0] = neg_ff;
   for (genvar a = 0; a < AXES; a++) begin : g_seed
      assign r_st[0][a] = r_ff[a];
      assign p_st[0][a] = '0;
      assign y_st[0][a] = '0;
   end

   for (genvar g = 0; g < ROOT_W; g++) begin : g_root
      tfn_root_step #(
         .BIT   (ROOT_W - 1 - g),
         .SUM_W (SUM_W),
         .RW    (RW),
         .PW    (PW)
      ) u_step (
         .clock   (clock),
         .en      (en),
         .s_in    (s_st[g]),
         .deg_in  (deg_st[g]),
         .neg_in  (neg_st[g]),
         .r_in    (r_st[g]),
         .p_in    (p_st[g]),
         .y_in    (y_st[g]),
         .s_out   (s_st[g+1]),
         .deg_out (deg_st[g+1]),
         .neg_out (neg_st[g+1]),
         .r_out   (r_st[g+1]),
         .p_out   (p_st[g+1]),
         .y_out   (y_st[g+1])
      );
   end

   // round half up: q = floor((y + 1) / 2); zero vector when degenerate
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         y_inc[i] = {1'b0, y_st[ROOT_W][i]} + (ROOT_W+1)'(1);
         if (deg_st[ROOT_W]) begin
            fmt[i] = '0;
         end else if (neg_st[ROOT_W][i]) begin
            fmt[i] = -$signed(y_inc[i][ROOT_W:1]);
         end else begin
            fmt[i] = $signed(y_inc[i][ROOT_W:1]);
         end
      end
   end

   assign arrive = en && v_ff[PIPE_N-1];
   assign take   = out_v_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= arrive;
         end
      end else if (arrive) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_n_ff   <= skid_n_ff;
            out_deg_ff <= skid_deg_ff;
         end else begin
            out_n_ff   <= fmt;
            out_deg_ff <= deg_st[ROOT_W];
         end
      end else if (arrive) begin
         skid_n_ff   <= fmt;
         skid_deg_ff <= deg_st[ROOT_W];
      end
   end

   assign rsp_if.valid      = out_v_ff;
   assign rsp_if.nx         = out_n_ff[0];
   assign rsp_if.ny         = out_n_ff[1];
   assign rsp_if.nz         = out_n_ff[2];
   assign rsp_if.degenerate = out_deg_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_deg_ff) |->
         (out_n_ff[0] == '0 && out_n_ff[1] == '0 && out_n_ff[2] == '0))
      else $error("degenerate result with nonzero normal");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_n_ff[0] <= UNIT_ONE && out_n_ff[0] >= -UNIT_ONE &&
                    out_n_ff[1] <= UNIT_ONE && out_n_ff[1] >= -UNIT_ONE &&
                    out_n_ff[2] <= UNIT_ONE && out_n_ff[2] >= -UNIT_ONE))
      else $error("normal component outside unit range");

endmodule

>>> design/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, edge products and cross product magnitude/sign (3 stages).
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic        [FIELD_W-1:0]       ax, ay, az,
   input  logic        [FIELD_W-1:0]       bx, by, bz,
   input  logic        [FIELD_W-1:0]       cx, cy, cz,
   output logic        [2*COORD_BITS+1:0]  mag_out [AXES],
   output logic        [AXES-1:0]          neg_out
);

   localparam int EDGE_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int MAG_W  = 2 * EDGE_W;

   logic signed [EDGE_W-1:0] va [AXES];
   logic signed [EDGE_W-1:0] vb [AXES];
   logic signed [EDGE_W-1:0] vc [AXES];

   logic signed [EDGE_W-1:0] e1_ff [AXES];
   logic signed [EDGE_W-1:0] e2_ff [AXES];
   logic signed [PROD_W-1:0] prod_ff [2*AXES];
   logic signed [PROD_W:0]   diff [AXES];
   logic        [MAG_W-1:0]  mag_in [AXES];
   logic        [MAG_W-1:0]  mag_ff [AXES];
   logic        [AXES-1:0]   neg_in;
   logic        [AXES-1:0]   neg_ff;

   // only the low COORD_BITS of each field count, sign-extended
   assign va[0] = EDGE_W'($signed(ax[COORD_BITS-1:0]));
   assign va[1] = EDGE_W'($signed(ay[COORD_BITS-1:0]));
   assign va[2] = EDGE_W'($signed(az[COORD_BITS-1:0]));
   assign vb[0] = EDGE_W'($signed(bx[COORD_BITS-1:0]));
   assign vb[1] = EDGE_W'($signed(by[COORD_BITS-1:0]));
   assign vb[2] = EDGE_W'($signed(bz[COORD_BITS-1:0]));
   assign vc[0] = EDGE_W'($signed(cx[COORD_BITS-1:0]));
   assign vc[1] = EDGE_W'($signed(cy[COORD_BITS-1:0]));
   assign vc[2] = EDGE_W'($signed(cz[COORD_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            e1_ff[i] <= vb[i] - va[i];
            e2_ff[i] <= vc[i] - vb[i];
         end
         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         diff[i]   = (PROD_W+1)'(prod_ff[2*i]) - (PROD_W+1)'(prod_ff[2*i+1]);
         neg_in[i] = diff[i][PROD_W];
         mag_in[i] = neg_in[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
   end

   assign mag_out = mag_ff;
   assign neg_out = neg_ff;

endmodule

>>> design/tfn_square.sv
// ----------------------------------------------------------------------------
// tfn_square
// Exact square of each magnitude from limb partial products (2 stages).
// ----------------------------------------------------------------------------
module tfn_square import tfn_pkg::*; #(
   parameter int MAG_W = 2 * COORD_BITS_DEF + 2
) (
   input  logic               clock,
   input  logic               en,
   input  logic [MAG_W-1:0]   mag_in [AXES],
   output logic [2*MAG_W-1:0] sq_out [AXES]
);

   localparam int LIMB_W = (MAG_W + 2) / 3;
   localparam int PAD_W  = 3 * LIMB_W;
   localparam int PART_W = 2 * LIMB_W;
   localparam int ACC_W  = 6 * LIMB_W;

   logic [PAD_W-1:0]   pad [AXES];
   logic [PART_W-1:0]  p00_ff [AXES], p11_ff [AXES], p22_ff [AXES];
   logic [PART_W-1:0]  p01_ff [AXES], p02_ff [AXES], p12_ff [AXES];
   logic [ACC_W-1:0]   acc [AXES];
   logic [2*MAG_W-1:0] sq_ff [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pad[i] = PAD_W'(mag_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            p00_ff[i] <= pad[i][LIMB_W-1:0]          * pad[i][LIMB_W-1:0];
            p11_ff[i] <= pad[i][2*LIMB_W-1:LIMB_W]   * pad[i][2*LIMB_W-1:LIMB_W];
            p22_ff[i] <= pad[i][3*LIMB_W-1:2*LIMB_W] * pad[i][3*LIMB_W-1:2*LIMB_W];
            p01_ff[i] <= pad[i][LIMB_W-1:0]          * pad[i][2*LIMB_W-1:LIMB_W];
            p02_ff[i] <= pad[i][LIMB_W-1:0]          * pad[i][3*LIMB_W-1:2*LIMB_W];
            p12_ff[i] <= pad[i][2*LIMB_W-1:LIMB_W]   * pad[i][3*LIMB_W-1:2*LIMB_W];
            sq_ff[i]  <= acc[i][2*MAG_W-1:0];
         end
      end
   end

   // cross terms appear twice in the square, hence the extra shift by one
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         acc[i] = ACC_W'(p00_ff[i])
                + (ACC_W'(p01_ff[i]) << (LIMB_W + 1))
                + (ACC_W'(p11_ff[i]) << (2 * LIMB_W))
                + (ACC_W'(p02_ff[i]) << (2 * LIMB_W + 1))
                + (ACC_W'(p12_ff[i]) << (3 * LIMB_W + 1))
                + (ACC_W'(p22_ff[i]) << (4 * LIMB_W));
      end
   end

   assign sq_out = sq_ff;

endmodule

>>> design/tfn_root_step.sv
// ----------------------------------------------------------------------------
// tfn_root_step
// One bit of y = floor(sqrt(T / s)) by restoring recurrence, three lanes.
// ----------------------------------------------------------------------------
module tfn_root_step import tfn_pkg::*; #(
   parameter int BIT   = ROOT_W - 1,
   parameter int SUM_W = 134,
   parameter int RW    = 198,
   parameter int PW    = 166
) (
   input  logic              clock,
   input  logic              en,
   input  logic [SUM_W-1:0]  s_in,
   input  logic              deg_in,
   input  logic [AXES-1:0]   neg_in,
   input  logic [RW-1:0]     r_in [AXES],
   input  logic [PW-1:0]     p_in [AXES],
   input  logic [ROOT_W-1:0] y_in [AXES],
   output logic [SUM_W-1:0]  s_out,
   output logic              deg_out,
   output logic [AXES-1:0]   neg_out,
   output logic [RW-1:0]     r_out [AXES],
   output logic [PW-1:0]     p_out [AXES],
   output logic [ROOT_W-1:0] y_out [AXES]
);

   logic [RW-1:0]     step [AXES];
   logic [AXES-1:0]   take;
   logic [RW-1:0]     r_in_d [AXES];
   logic [PW-1:0]     p_in_d [AXES];
   logic [ROOT_W-1:0] y_in_d [AXES];

   logic [SUM_W-1:0]  s_ff;
   logic              deg_ff;
   logic [AXES-1:0]   neg_ff;
   logic [RW-1:0]     r_ff [AXES];
   logic [PW-1:0]     p_ff [AXES];
   logic [ROOT_W-1:0] y_ff [AXES];

   // (y + 2^BIT)^2 s - y^2 s = 2^(BIT+1) * (y s) + 2^(2 BIT) * s, with p = y s
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         step[i] = (RW'(p_in[i]) << (BIT + 1)) + (RW'(s_in) << (2 * BIT));
         take[i] = (r_in[i] >= step[i]);
         r_in_d[i] = take[i] ? r_in[i] - step[i] : r_in[i];
         p_in_d[i] = take[i] ? p_in[i] + (PW'(s_in) << BIT) : p_in[i];
         y_in_d[i] = y_in[i];
         y_in_d[i][BIT] = take[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_in;
         deg_ff <= deg_in;
         neg_ff <= neg_in;
         r_ff   <= r_in_d;
         p_ff   <= p_in_d;
         y_ff   <= y_in_d;
      end
   end

   assign s_out   = s_ff;
   assign deg_out = deg_ff;
   assign neg_out = neg_ff;
   assign r_out   = r_ff;
   assign p_out   = p_ff;
   assign y_out   = y_ff;

endmodule

>>> verif/tb_triangle_face_normal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_core
// Streams triangles into the face normal core and checks every unit normal
// against an exact predictor. The predictor uses wide integer arithmetic and a
// bisection on the rounding boundary. Covered: directed extremes, degenerate
// triangles and random triangles, with random gaps on both channels and one
// long output stall.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_core;
   import tfn_pkg::*;

   typedef logic signed [FIELD_W-1:0] coord_t;
   typedef coord_t                    tri_t [9];
   typedef struct {
      logic signed [NORM_W-1:0] n [3];
      logic                     degenerate;
   } normal_t;

   logic clock;
   logic reset;

   tfn_req_if req_if ();
   tfn_rsp_if rsp_if ();

   triangle_face_normal_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   normal_t expected_normals [$];
   int      mismatches;
   bit      hold_output;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Exact unit normal: cross product of b-a and c-b, each component rounded
   // half away from zero to Q2.30.
   function automatic normal_t predict_normal(tri_t p);
      logic signed [33:0] e1 [3];
      logic signed [33:0] e2 [3];
      logic signed [67:0] cr [3];
      logic        [66:0] mag [3];
      logic               neg [3];
      logic       [255:0] sum, msq, odd, lhs;
      logic        [31:0] lo, hi, mid;
      normal_t            r;
      for (int i = 0; i < 3; i++) begin
         e1[i] = 34'(p[3+i]) - 34'(p[i]);
         e2[i] = 34'(p[6+i]) - 34'(p[3+i]);
      end
      cr[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
      cr[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
      cr[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i][67];
         mag[i] = neg[i] ? 67'(-cr[i]) : 67'(cr[i]);
         sum    = sum + 256'(mag[i]) * 256'(mag[i]);
      end
      r.degenerate = (sum == '0);
      for (int i = 0; i < 3; i++) begin
         r.n[i] = '0;
         if (!r.degenerate) begin
            msq = (256'(mag[i]) * 256'(mag[i])) << FRAC_SHIFT;
            lo  = 0;
            hi  = 32'(UNIT_ONE);
            // largest q with (2q-1)^2 * |n|^2 <= 2^62 * m^2
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               odd = 256'(mid) * 2 - 1;
               lhs = odd * odd * sum;
               if (lhs <= msq) lo = mid;
               else            hi = mid - 1;
            end
            r.n[i] = neg[i] ? -lo : lo;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("ERROR t=%0t %s: got %0d expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   // Result checker
   always @(posedge clock) begin
      normal_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_normals.size() == 0) begin
            report_mismatch("pending results", 1, 0);
         end else begin
            want = expected_normals.pop_front();
            if (rsp_if.nx !== want.n[0]) report_mismatch("nx", rsp_if.nx, want.n[0]);
            if (rsp_if.ny !== want.n[1]) report_mismatch("ny", rsp_if.ny, want.n[1]);
            if (rsp_if.nz !== want.n[2]) report_mismatch("nz", rsp_if.nz, want.n[2]);
            if (rsp_if.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_if.degenerate, want.degenerate);
         end
      end
   end

   // Result side ready: random stalls, or a long hold when requested
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_if.ready <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_output = 1'b0;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_if.ready <= 1'b1;
         end else begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   task automatic send_triangle(tri_t p);
      req_if.valid <= 1'b1;
      req_if.ax <= p[0]; req_if.ay <= p[1]; req_if.az <= p[2];
      req_if.bx <= p[3]; req_if.by <= p[4]; req_if.bz <= p[5];
      req_if.cx <= p[6]; req_if.cy <= p[7]; req_if.cz <= p[8];
      do @(posedge clock); while (!req_if.ready);
      expected_normals.push_back(predict_normal(p));
   endtask

   // Idle the request side for a random gap, mostly short, sometimes long
   task automatic idle_requests(bit allow);
      int gap;
      if (!allow) return;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
          : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic tri_t make_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx,
                                     coord_t by, coord_t bz, coord_t cx, coord_t cy,
                                     coord_t cz);
      tri_t p;
      p = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return p;
   endfunction

   task automatic test_directed_extremes();
      coord_t mx, mn, one;
      mx  = 32'sh7fff_ffff;
      mn  = 32'sh8000_0000;
      one = 32'sh0001_0000;
      // axis-aligned faces give exact unit components of either sign; the last is a diagonal face
      send_triangle(make_tri(0, 0, 0, one, 0, 0, one, one, 0)); idle_requests(1);
      send_triangle(make_tri(0, 0, 0, 0, one, 0, one, one, 0)); idle_requests(1);
      send_triangle(make_tri(0, 0, 0, 0, one, 0, 0, one, one)); idle_requests(1);
      send_triangle(make_tri(0, 0, 0, 0, 0, one, one, 0, one)); idle_requests(1);
      send_triangle(make_tri(0, 0, 0, one, 0, 0, one, 0, -one)); idle_requests(1);
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1)); idle_requests(1);
      // largest edges and cross product, then small mixed-sign triangles
      send_triangle(make_tri(mn, mn, mn, mx, mn, mn, mx, mx, mn)); idle_requests(1);
      send_triangle(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx)); idle_requests(1);
      send_triangle(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn)); idle_requests(1);
      send_triangle(make_tri(mn, mn, mx, mx, mx, mn, mn, mx, mx)); idle_requests(1);
      send_triangle(make_tri(mx, mx, mx, mn, mn, mx, mx, mn, mn)); idle_requests(1);
      send_triangle(make_tri(0, -1, 1, -1, 1, 0, 1, 0, -1)); idle_requests(1);
      send_triangle(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 10)); idle_requests(1);
      send_triangle(make_tri(-3, 7, 0, 5, -2, 9, 11, 4, -6)); idle_requests(1);
   endtask

   task automatic test_degenerate();
      coord_t mx, mn;
      mx = 32'sh7fff_ffff;
      mn = 32'sh8000_0000;
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0)); idle_requests(1);
      send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx)); idle_requests(1);
      send_triangle(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn)); idle_requests(1);
      send_triangle(make_tri(mn, mn, mn, mx, mx, mx, mn, mn, mn)); idle_requests(1);
      send_triangle(make_tri(mn, 0, mx, 0, 0, 0, mx, 0, mn)); idle_requests(1);
      send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9)); idle_requests(1);
      send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, -9, 3)); idle_requests(1);
   endtask

   function automatic tri_t random_triangle();
      tri_t p;
      int   kind, k;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (kind < 5)      p[i] = $urandom();
         else if (kind < 8) p[i] = $signed($urandom_range(0, 2 ** 21)) - (2 ** 20);
         else               p[i] = $signed($urandom_range(0, 2 ** 17)) - (2 ** 16);
      end
      if (kind == 8) begin
         // collinear: c continues the line through a and b
         k = $urandom_range(0, 6) - 3;
         for (int i = 0; i < 3; i++) p[6+i] = p[3+i] + k * (p[3+i] - p[i]);
      end else if (kind == 9 && $urandom_range(0, 1)) begin
         for (int i = 0; i < 3; i++) p[3+i] = p[i];
      end
      return p;
   endfunction

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         send_triangle(random_triangle());
         // back-to-back stretches with no idling
         idle_requests((n / 100) % 3 != 1);
      end
   endtask

   task automatic test_backpressure();
      hold_output = 1'b1;
      for (int n = 0; n < 60; n++) send_triangle(random_triangle());
   endtask

   initial begin
      mismatches   = 0;
      hold_output  = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.ax = '0; req_if.ay = '0; req_if.az = '0;
      req_if.bx = '0; req_if.by = '0; req_if.bz = '0;
      req_if.cx = '0; req_if.cy = '0; req_if.cz = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_degenerate();
      test_random(500);
      test_backpressure();
      test_random(480);

      req_if.valid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
